/* src/grd_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the reachability block.
package grd_pkg;

  localparam int MAX_NODES_DEF = 64;

  localparam logic [1:0] ACT_DIRECTED   = 2'd0;
  localparam logic [1:0] ACT_UNDIRECTED = 2'd1;
  localparam logic [1:0] ACT_QUERY      = 2'd2;

  localparam logic [1:0] SEL_A   = 2'd0;
  localparam logic [1:0] SEL_B   = 2'd1;
  localparam logic [1:0] SEL_CUR = 2'd2;

  typedef struct packed {
    logic       latch;
    logic [1:0] adj_sel;
    logic       adj_wr;
    logic       wr_second;
    logic       q_init;
    logic       stk_pop;
    logic       scan;
    logic       push;
    logic       res_load;
  } cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic cand_empty;
    logic fill_zero;
  } sts_t;

endpackage

/* src/grd_ctrl.sv */
// Controller state machine that sequences edge updates and the depth-first walk.
module grd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        action,
  output logic              out_valid,
  input  logic              out_ready,
  input  grd_pkg::sts_t     sts,
  output grd_pkg::cmd_t     cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_E_RD   = 4'd1;
  localparam logic [3:0] S_E_WR   = 4'd2;
  localparam logic [3:0] S_E_RD2  = 4'd3;
  localparam logic [3:0] S_E_WR2  = 4'd4;
  localparam logic [3:0] S_Q_INIT = 4'd5;
  localparam logic [3:0] S_POP    = 4'd6;
  localparam logic [3:0] S_ROW    = 4'd7;
  localparam logic [3:0] S_SCAN   = 4'd8;
  localparam logic [3:0] S_PUSH   = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       undirected;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    cmd.adj_sel   = grd_pkg::SEL_CUR;
    unique case (state)
      S_IDLE: begin
        cmd.latch = accept;
        if (accept) begin
          priority if (action == grd_pkg::ACT_DIRECTED ||
                        action == grd_pkg::ACT_UNDIRECTED) begin
            state_next = sts.idx_ok ? S_E_RD : S_IDLE;
          end else if (action == grd_pkg::ACT_QUERY) begin
            // An out-of-range query skips the walk and answers 0.
            state_next = sts.idx_ok ? S_Q_INIT : S_DONE;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_E_RD: begin
        cmd.adj_sel = grd_pkg::SEL_A;
        state_next  = S_E_WR;
      end
      S_E_WR: begin
        cmd.adj_wr = 1'b1;
        state_next = undirected ? S_E_RD2 : S_IDLE;
      end
      S_E_RD2: begin
        cmd.adj_sel = grd_pkg::SEL_B;
        state_next  = S_E_WR2;
      end
      S_E_WR2: begin
        cmd.adj_wr    = 1'b1;
        cmd.wr_second = 1'b1;
        state_next    = S_IDLE;
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_next = S_POP;
      end
      S_POP: begin
        cmd.stk_pop = 1'b1;
        state_next  = S_ROW;
      end
      S_ROW: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan   = 1'b1;
        state_next = S_PUSH;
      end
      S_PUSH: begin
        priority if (!sts.cand_empty) begin
          cmd.push = 1'b1;
        end else if (sts.fill_zero) begin
          state_next = S_DONE;
        end else begin
          state_next = S_POP;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      undirected <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        undirected <= (action == grd_pkg::ACT_UNDIRECTED);
      end
      if (cmd.res_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* src/grd_dp.sv */
// Datapath: adjacency memory, node stack, visited set, candidate scan and result register.
module grd_dp #(
  parameter int MAX_NODES = grd_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic [5:0]         from_node,
  input  logic [5:0]         to_node,
  input  logic signed [15:0] edge_weight,
  input  grd_pkg::cmd_t      cmd,
  output grd_pkg::sts_t      sts,
  output logic               reachable
);

  localparam int NODE_W = $clog2(MAX_NODES);
  localparam int FILL_W = $clog2(MAX_NODES + 1);
  localparam int CW     = (FILL_W > 7) ? FILL_W : 7;

  logic [6:0]            node_count;
  logic [CW-1:0]         nc_ext;
  logic [CW-1:0]         count;
  logic [MAX_NODES-1:0]  mask;

  logic [NODE_W-1:0]     a_q;
  logic [NODE_W-1:0]     b_q;
  logic                  present_q;
  logic                  ok_q;

  logic [MAX_NODES-1:0]  adj_mem [MAX_NODES];
  logic [MAX_NODES-1:0]  row_valid;
  logic [MAX_NODES-1:0]  adj_q;
  logic                  adj_v_q;
  logic [MAX_NODES-1:0]  adj_row;
  logic [NODE_W-1:0]     rd_row;
  logic [NODE_W-1:0]     wr_row;
  logic [NODE_W-1:0]     wr_col;
  logic [MAX_NODES-1:0]  col_bit;
  logic [MAX_NODES-1:0]  new_row;

  logic [NODE_W-1:0]     node_stack [MAX_NODES];
  logic [NODE_W-1:0]     stk_q;
  logic [FILL_W-1:0]     fill;
  logic [FILL_W-1:0]     fill_m1;
  logic [NODE_W-1:0]     stk_wa;
  logic [NODE_W-1:0]     stk_wd;

  logic [MAX_NODES-1:0]  visited;
  logic [MAX_NODES-1:0]  cand;
  logic [MAX_NODES-1:0]  cand_new;
  logic [MAX_NODES-1:0]  low;
  logic [NODE_W-1:0]     push_idx;
  logic                  res;

  // Nodes in use, with a register value above the array size acting as the array size.
  assign nc_ext = CW'(node_count);
  assign count  = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      mask[i] = (CW'(i) < count);
    end
  end

  assign sts.idx_ok     = (CW'(from_node) < count) && (CW'(to_node) < count);
  assign sts.cand_empty = (cand == '0);
  assign sts.fill_zero  = (fill == '0);

  // A row never written since reset reads as all zero.
  assign adj_row = adj_v_q ? adj_q : '0;

  always_comb begin
    unique case (cmd.adj_sel)
      grd_pkg::SEL_A:   rd_row = a_q;
      grd_pkg::SEL_B:   rd_row = b_q;
      default:          rd_row = stk_q;
    endcase
  end

  assign wr_row  = cmd.wr_second ? b_q : a_q;
  assign wr_col  = cmd.wr_second ? a_q : b_q;
  assign col_bit = MAX_NODES'(1) << wr_col;
  assign new_row = present_q ? (adj_row | col_bit) : (adj_row & ~col_bit);

  // Self loops are never followed, and nodes beyond the count are not scanned.
  assign cand_new = adj_row & ~visited & mask & ~(MAX_NODES'(1) << stk_q);

  assign low = cand & (~cand + MAX_NODES'(1));

  always_comb begin
    push_idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (low[i]) begin
        push_idx = push_idx | NODE_W'(i);
      end
    end
  end

  assign fill_m1 = fill - FILL_W'(1);
  assign stk_wa  = cmd.q_init ? '0 : fill[NODE_W-1:0];
  assign stk_wd  = cmd.q_init ? a_q : push_idx;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      a_q       <= NODE_W'(from_node);
      b_q       <= NODE_W'(to_node);
      present_q <= (edge_weight != '0);
      ok_q      <= sts.idx_ok;
    end
  end

  always_ff @(posedge clk) begin
    adj_q   <= adj_mem[rd_row];
    adj_v_q <= row_valid[rd_row];
    if (cmd.adj_wr) begin
      adj_mem[wr_row] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.q_init || cmd.push) begin
      node_stack[stk_wa] <= stk_wd;
    end
    if (cmd.stk_pop) begin
      stk_q <= node_stack[fill_m1[NODE_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= 7'd64;
      row_valid  <= '0;
      fill       <= '0;
      visited    <= '0;
      cand       <= '0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      if (cmd.adj_wr) begin
        row_valid[wr_row] <= 1'b1;
      end
      priority if (cmd.q_init) begin
        fill <= FILL_W'(1);
      end else if (cmd.stk_pop) begin
        fill <= fill_m1;
      end else if (cmd.push) begin
        fill <= fill + FILL_W'(1);
      end
      // All new neighbors are marked at once; the walk pushes them one per cycle.
      priority if (cmd.q_init) begin
        visited <= MAX_NODES'(1) << a_q;
      end else if (cmd.scan) begin
        visited <= visited | cand_new;
      end
      priority if (cmd.scan) begin
        cand <= cand_new;
      end else if (cmd.push) begin
        cand <= cand & ~low;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res <= ok_q & visited[b_q];
    end
  end

  assign reachable = res;

endmodule

/* src/graph_reachability_dfs.sv */
// An edge update reads the row and writes it back, for an undirected edge once per direction;
// an out-of-range edge is dropped. A query walks the graph with one adjacency memory row read
// per popped node and one stack push per cycle; an out-of-range query answers 0 without a walk.
// One item is worked on at a time; a result waits in the output register.
// Reset is synchronous: node_count returns to 64, all adjacency row valid bits clear so the
// matrix reads as all zero at once, the visited set and stack clear, and the block goes idle.
module graph_reachability_dfs #(
  parameter int MAX_NODES = grd_pkg::MAX_NODES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         action,
  input  logic [5:0]         from_node,
  input  logic [5:0]         to_node,
  input  logic signed [15:0] edge_weight,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               reachable
);

  grd_pkg::cmd_t cmd;
  grd_pkg::sts_t sts;

  grd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .action    (action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  grd_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .from_node   (from_node),
    .to_node     (to_node),
    .edge_weight (edge_weight),
    .cmd         (cmd),
    .sts         (sts),
    .reachable   (reachable)
  );

  // A pending result is never overwritten before its transfer.
  assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register loaded while a result is pending");

  // A pop never happens on an empty stack.
  assert property (@(posedge clk) disable iff (rst)
    cmd.stk_pop |-> !sts.fill_zero)
    else $error("stack pop with empty stack");

  // A push only happens while candidates remain.
  assert property (@(posedge clk) disable iff (rst)
    cmd.push |-> !sts.cand_empty)
    else $error("stack push without a candidate");

  // A query transfer keeps the input closed in the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && action == grd_pkg::ACT_QUERY) |=> !in_ready)
    else $error("input reopened right after a query transfer");

endmodule
